/* hdl/ebpf_pkg.sv */
// Shared types and constants of the eBPF program executor.
// Item structs, instruction field codes, status codes and the
// controller-to-datapath command and status groups. No dependencies.
package ebpf_pkg;

  localparam int NUM_REGS           = 11;
  localparam int RF_AW              = $clog2(NUM_REGS);
  localparam logic [15:0] DEFAULT_STEP_LIMIT = 16'd128;
  localparam logic [63:0] SHIFT_BOUND        = 64'd32;
  localparam logic [63:0] SIGN64             = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SIGN32             = 64'h0000_0000_8000_0000;

  // Status codes reported with every result item.
  localparam logic [2:0] STAT_OK     = 3'd0;
  localparam logic [2:0] STAT_PC     = 3'd1;
  localparam logic [2:0] STAT_STEPS  = 3'd2;
  localparam logic [2:0] STAT_DIV0   = 3'd3;
  localparam logic [2:0] STAT_SHIFT  = 3'd4;
  localparam logic [2:0] STAT_MOD    = 3'd5;
  localparam logic [2:0] STAT_OPCODE = 3'd6;
  localparam logic [2:0] STAT_ADDR   = 3'd7;

  // Instruction classes.
  localparam logic [2:0] CLS_LD    = 3'd0;
  localparam logic [2:0] CLS_LDX   = 3'd1;
  localparam logic [2:0] CLS_ST    = 3'd2;
  localparam logic [2:0] CLS_STX   = 3'd3;
  localparam logic [2:0] CLS_ALU   = 3'd4;
  localparam logic [2:0] CLS_JMP   = 3'd5;
  localparam logic [2:0] CLS_JMP32 = 3'd6;
  localparam logic [2:0] CLS_ALU64 = 3'd7;

  localparam logic [7:0] OP_LD_IMM32 = 8'h00;
  localparam logic [7:0] OP_LDDW     = 8'h18;
  localparam logic [2:0] MODE_MEM    = 3'b011;

  // ALU operations (upper opcode nibble).
  localparam logic [3:0] ALU_ADD  = 4'h0;
  localparam logic [3:0] ALU_SUB  = 4'h1;
  localparam logic [3:0] ALU_MUL  = 4'h2;
  localparam logic [3:0] ALU_DIV  = 4'h3;
  localparam logic [3:0] ALU_OR   = 4'h4;
  localparam logic [3:0] ALU_AND  = 4'h5;
  localparam logic [3:0] ALU_LSH  = 4'h6;
  localparam logic [3:0] ALU_RSH  = 4'h7;
  localparam logic [3:0] ALU_NEG  = 4'h8;
  localparam logic [3:0] ALU_MOD  = 4'h9;
  localparam logic [3:0] ALU_XOR  = 4'hA;
  localparam logic [3:0] ALU_MOV  = 4'hB;
  localparam logic [3:0] ALU_ARSH = 4'hC;

  // Jump conditions (upper opcode nibble).
  localparam logic [3:0] JMP_JA   = 4'h0;
  localparam logic [3:0] JMP_JEQ  = 4'h1;
  localparam logic [3:0] JMP_JGT  = 4'h2;
  localparam logic [3:0] JMP_JGE  = 4'h3;
  localparam logic [3:0] JMP_JSET = 4'h4;
  localparam logic [3:0] JMP_JNE  = 4'h5;
  localparam logic [3:0] JMP_JSGT = 4'h6;
  localparam logic [3:0] JMP_JSGE = 4'h7;
  localparam logic [3:0] JMP_JLT  = 4'hA;
  localparam logic [3:0] JMP_JLE  = 4'hB;
  localparam logic [3:0] JMP_JSLT = 4'hC;
  localparam logic [3:0] JMP_JSLE = 4'hD;

  typedef struct packed {
    logic [7:0]         opcode;
    logic [3:0]         dst_index;
    logic [3:0]         src_index;
    logic signed [15:0] offset;
    logic signed [31:0] immediate;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         reg_index;
    logic signed [63:0] reg_value;
    logic               end_of_report;
  } out_item_t;

  typedef enum logic [1:0] {RSEL_DST, RSEL_SRC, RSEL_RPT} rsel_t;
  typedef enum logic [2:0] {WB_IMM, WB_LDDW, WB_ALU, WB_MUL, WB_DIV, WB_LOAD} wb_sel_t;
  typedef enum logic [1:0] {PC_HOLD, PC_INC1, PC_INC2, PC_JUMP} pc_op_t;

  typedef struct packed {
    logic       load_word;
    logic       start_run;
    logic       fetch;
    logic       ir_load;
    rsel_t      rsel;
    logic       rd_load;
    logic       rs_load;
    logic       prog_rd_next;
    logic       rf_we;
    wb_sel_t    wb_sel;
    pc_op_t     pc_op;
    logic       addr_load;
    logic       ld_cap;
    logic       st_write;
    logic       mul_start;
    logic       mul_step;
    logic       div_start;
    logic       clr_step;
    logic       out_load;
    logic       rpt_next;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic       bad_reg;
    logic       pc_eq_len;
    logic       pc_over;
    logic       step_hit;
    logic       lddw_end;
    logic       b_zero;
    logic       b_neg;
    logic       b_ge32;
    logic       addr_ok;
    logic       byte_last;
    logic       mul_last;
    logic       div_busy;
    logic       clr_last;
    logic       rpt_last;
  } dp_status_t;

endpackage

/* hdl/ebpf_program_executor.sv */
// Top level of the eBPF program executor.
// Joins ebpf_ctrl and ebpf_datapath; uses ebpf_pkg.
//
// Usage: instruction words arrive on the item channel (item_valid, item_stall,
// item). Each accepted item is one 64-bit program word; a word with last set
// ends the program and starts a run. Words beyond PROGRAM_DEPTH are dropped,
// but a dropped last word still starts the run. During a run item_stall stays
// high. Each instruction passes through check, fetch, register reads and
// dispatch; multiply adds its partial-product steps, divide and modulo wait for
// the bit-serial divider, a wide load reads the following word, and stores and
// loads go byte by byte (byte-wide port).
// After the run the block sends eleven result items on the result
// channel, one per register r0..r10, each carrying the run's status; the last
// has end_of_report set. The payload of each report item holds while
// result_stall is high.
// The step limit is written through step_limit_we and step_limit_data while
// the block is idle; it resets to 128.
// After reset the block clears the scratch memory, one byte per cycle, with
// item_stall high; the scratch memory then keeps its contents across runs,
// while registers are cleared at each run start.
module ebpf_program_executor #(
  parameter int PROGRAM_DEPTH = 256,
  parameter int SCRATCH_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  ebpf_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output ebpf_pkg::out_item_t result,
  input  logic                step_limit_we,
  input  logic [15:0]         step_limit_data
);
  import ebpf_pkg::*;

  cmd_t       cmd;
  dp_status_t st;

  // The controller sequences every phase; apart from step limit writes, the datapath only acts on commands.
  ebpf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_last    (item.last),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .st           (st),
    .cmd          (cmd)
  );

  ebpf_datapath #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .SCRATCH_BYTES (SCRATCH_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .item            (item),
    .step_limit_we   (step_limit_we),
    .step_limit_data (step_limit_data),
    .cmd             (cmd),
    .st              (st),
    .result          (result)
  );

endmodule

/* hdl/ebpf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ebpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ebpf_divider.sv */
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// Depends on nothing.
module ebpf_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quotient,
  output logic [63:0] remainder
);

  logic [63:0] dvsr;
  logic [6:0]  count;
  logic [64:0] trial;

  assign trial = {remainder, quotient[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      count     <= 7'd64;
      quotient  <= dividend;
      remainder <= '0;
      dvsr      <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvsr}) begin
        remainder <= 64'(trial - {1'b0, dvsr});
        quotient  <= {quotient[62:0], 1'b1};
      end else begin
        remainder <= trial[63:0];
        quotient  <= {quotient[62:0], 1'b0};
      end
      count <= count - 7'd1;
      if (count == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* hdl/ebpf_ctrl.sv */
// Controller state machine of the eBPF program executor.
// Sequences loading, execution and reporting; uses ebpf_pkg.
module ebpf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_last,
  output logic                item_stall,
  output logic                result_valid,
  input  logic                result_stall,
  input  ebpf_pkg::dp_status_t st,
  output ebpf_pkg::cmd_t       cmd
);
  import ebpf_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_LOAD, S_START, S_CHECK, S_IR, S_READ_D, S_READ_S, S_GET_S,
    S_DISPATCH, S_LDDW_RD, S_LDDW_WR, S_ADDR, S_ADDR_CHK, S_LD_ISSUE,
    S_LD_CAP, S_MEM_WB, S_ST, S_MUL, S_MUL_WB, S_DIV_WAIT, S_RPT_RD,
    S_RPT_OUT, S_RPT_HOLD
  } state_t;

  state_t     state, state_next;
  logic [2:0] status, status_next;
  logic [2:0] cls;
  logic [3:0] op_hi;
  logic       xsrc;

  assign cls   = st.opcode[2:0];
  assign op_hi = st.opcode[7:4];
  assign xsrc  = st.opcode[3];
  assign item_stall = (state != S_LOAD);

  always_comb begin
    cmd         = '0;
    cmd.rsel    = RSEL_DST;
    cmd.wb_sel  = WB_ALU;
    cmd.pc_op   = PC_HOLD;
    cmd.status  = status;
    state_next  = state;
    status_next = status;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_word = item_valid;
        if (item_valid && item_last) state_next = S_START;
      end
      S_START: begin
        cmd.start_run = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.pc_eq_len) begin
          status_next = STAT_OK;
          state_next  = S_RPT_RD;
        end else if (st.pc_over) begin
          status_next = STAT_PC;
          state_next  = S_RPT_RD;
        end else if (st.step_hit) begin
          status_next = STAT_STEPS;
          state_next  = S_RPT_RD;
        end else begin
          cmd.fetch  = 1'b1;
          state_next = S_IR;
        end
      end
      S_IR: begin
        cmd.ir_load = 1'b1;
        state_next  = S_READ_D;
      end
      S_READ_D: begin
        cmd.rsel   = RSEL_DST;
        state_next = S_READ_S;
      end
      S_READ_S: begin
        cmd.rsel    = RSEL_SRC;
        cmd.rd_load = 1'b1;
        state_next  = S_GET_S;
      end
      S_GET_S: begin
        cmd.rs_load = 1'b1;
        state_next  = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_next  = S_RPT_RD;
        status_next = STAT_OPCODE;
        if (!st.bad_reg) begin
          case (cls)
            CLS_LD: begin
              if (st.opcode == OP_LD_IMM32) begin
                cmd.rf_we   = 1'b1;
                cmd.wb_sel  = WB_IMM;
                cmd.pc_op   = PC_INC1;
                state_next  = S_CHECK;
                status_next = status;
              end else if (st.opcode == OP_LDDW) begin
                if (st.lddw_end) begin
                  status_next = STAT_PC;
                end else begin
                  state_next  = S_LDDW_RD;
                  status_next = status;
                end
              end
            end
            CLS_LDX, CLS_ST, CLS_STX: begin
              if (st.opcode[7:5] == MODE_MEM) begin
                cmd.addr_load = 1'b1;
                state_next    = S_ADDR;
                status_next   = status;
              end
            end
            CLS_ALU, CLS_ALU64: begin
              case (op_hi)
                ALU_ADD, ALU_SUB, ALU_OR, ALU_AND, ALU_XOR, ALU_MOV: begin
                  cmd.rf_we   = 1'b1;
                  cmd.pc_op   = PC_INC1;
                  state_next  = S_CHECK;
                  status_next = status;
                end
                ALU_NEG: begin
                  if (!xsrc) begin
                    cmd.rf_we   = 1'b1;
                    cmd.pc_op   = PC_INC1;
                    state_next  = S_CHECK;
                    status_next = status;
                  end
                end
                ALU_LSH, ALU_RSH, ALU_ARSH: begin
                  if (st.b_ge32) begin
                    status_next = STAT_SHIFT;
                  end else begin
                    cmd.rf_we   = 1'b1;
                    cmd.pc_op   = PC_INC1;
                    state_next  = S_CHECK;
                    status_next = status;
                  end
                end
                ALU_MUL: begin
                  cmd.mul_start = 1'b1;
                  state_next    = S_MUL;
                  status_next   = status;
                end
                ALU_DIV: begin
                  if (st.b_zero) begin
                    status_next = STAT_DIV0;
                  end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_WAIT;
                    status_next   = status;
                  end
                end
                ALU_MOD: begin
                  if (st.b_zero || st.b_neg) begin
                    status_next = STAT_MOD;
                  end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_WAIT;
                    status_next   = status;
                  end
                end
                default: begin
                  status_next = STAT_OPCODE;
                end
              endcase
            end
            CLS_JMP, CLS_JMP32: begin
              case (op_hi)
                JMP_JA: begin
                  if (!xsrc) begin
                    cmd.pc_op   = PC_JUMP;
                    state_next  = S_CHECK;
                    status_next = status;
                  end
                end
                JMP_JEQ, JMP_JGT, JMP_JGE, JMP_JSET, JMP_JNE, JMP_JSGT, JMP_JSGE,
                JMP_JLT, JMP_JLE, JMP_JSLT, JMP_JSLE: begin
                  cmd.pc_op   = PC_JUMP;
                  state_next  = S_CHECK;
                  status_next = status;
                end
                default: begin
                  status_next = STAT_OPCODE;
                end
              endcase
            end
            default: begin
              status_next = STAT_OPCODE;
            end
          endcase
        end
      end
      S_LDDW_RD: begin
        cmd.prog_rd_next = 1'b1;
        state_next = S_LDDW_WR;
      end
      S_LDDW_WR: begin
        cmd.rf_we  = 1'b1;
        cmd.wb_sel = WB_LDDW;
        cmd.pc_op  = PC_INC2;
        state_next = S_CHECK;
      end
      S_ADDR: begin
        state_next = S_ADDR_CHK;
      end
      S_ADDR_CHK: begin
        if (!st.addr_ok) begin
          status_next = STAT_ADDR;
          state_next  = S_RPT_RD;
        end else if (cls == CLS_LDX) begin
          state_next = S_LD_ISSUE;
        end else begin
          state_next = S_ST;
        end
      end
      S_LD_ISSUE: begin
        state_next = S_LD_CAP;
      end
      S_LD_CAP: begin
        cmd.ld_cap = 1'b1;
        state_next = st.byte_last ? S_MEM_WB : S_LD_ISSUE;
      end
      S_MEM_WB: begin
        cmd.rf_we  = 1'b1;
        cmd.wb_sel = WB_LOAD;
        cmd.pc_op  = PC_INC1;
        state_next = S_CHECK;
      end
      S_ST: begin
        cmd.st_write = 1'b1;
        if (st.byte_last) begin
          cmd.pc_op  = PC_INC1;
          state_next = S_CHECK;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (st.mul_last) state_next = S_MUL_WB;
      end
      S_MUL_WB: begin
        cmd.rf_we  = 1'b1;
        cmd.wb_sel = WB_MUL;
        cmd.pc_op  = PC_INC1;
        state_next = S_CHECK;
      end
      S_DIV_WAIT: begin
        if (!st.div_busy) begin
          cmd.rf_we  = 1'b1;
          cmd.wb_sel = WB_DIV;
          cmd.pc_op  = PC_INC1;
          state_next = S_CHECK;
        end
      end
      S_RPT_RD: begin
        cmd.rsel   = RSEL_RPT;
        state_next = S_RPT_OUT;
      end
      S_RPT_OUT: begin
        cmd.out_load = 1'b1;
        state_next   = S_RPT_HOLD;
      end
      S_RPT_HOLD: begin
        cmd.rsel = RSEL_RPT;
        if (!result_stall) begin
          if (st.rpt_last) begin
            state_next = S_LOAD;
          end else begin
            cmd.rpt_next = 1'b1;
            state_next   = S_RPT_RD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      status       <= STAT_OK;
      result_valid <= 1'b0;
    end else begin
      state  <= state_next;
      status <= status_next;
      if (state == S_RPT_OUT) begin
        result_valid <= 1'b1;
      end else if (state == S_RPT_HOLD && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/ebpf_datapath.sv */
// Datapath of the eBPF program executor: program store, register file,
// scratch memory, ALU, multiplier, divider and report register.
// Uses ebpf_pkg, ebpf_ram and ebpf_divider.
module ebpf_datapath #(
  parameter int PROGRAM_DEPTH = 256,
  parameter int SCRATCH_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ebpf_pkg::in_item_t   item,
  input  logic                 step_limit_we,
  input  logic [15:0]          step_limit_data,
  input  ebpf_pkg::cmd_t       cmd,
  output ebpf_pkg::dp_status_t st,
  output ebpf_pkg::out_item_t  result
);
  import ebpf_pkg::*;

  localparam int AW  = $clog2(PROGRAM_DEPTH);
  localparam int LW  = $clog2(PROGRAM_DEPTH + 1);
  localparam int PCW = ((LW > 16) ? LW : 16) + 2;
  localparam int SAW = $clog2(SCRATCH_BYTES);
  localparam logic [LW-1:0]  DEPTH_L   = LW'(PROGRAM_DEPTH);
  localparam logic [63:0]    SCR_BYTES = 64'(SCRATCH_BYTES);
  localparam logic [SAW-1:0] SCR_LAST  = SAW'(SCRATCH_BYTES - 1);
  localparam logic [3:0]     RPT_LAST  = 4'(NUM_REGS - 1);

  // Control state.
  logic [15:0]         step_limit;
  logic [LW-1:0]       load_count, len;
  logic signed [PCW-1:0] pc;
  logic [15:0]         steps;
  logic [NUM_REGS-1:0] rf_valid;
  logic                rf_vld_q;
  logic [3:0]          rpt_k;
  logic [2:0]          bi;
  logic [1:0]          mul_cnt;
  logic [SAW-1:0]      clr_cnt;

  // Payload registers.
  logic [63:0] ir;
  logic [63:0] rd_val, rs_val, addr, ld_val, prod, acc;
  logic        na, nb;

  // Instruction fields.
  logic [7:0]  op;
  logic [3:0]  ir_dst, ir_src;
  logic [15:0] ir_off;
  logic [31:0] ir_imm;
  logic [2:0]  cls;
  logic [3:0]  op_hi;
  logic [63:0] imm64, off64, b;
  logic signed [PCW-1:0] off_pc, len_pc, pc1, pc2, pc_tgt;

  assign op     = ir[7:0];
  assign ir_dst = ir[11:8];
  assign ir_src = ir[15:12];
  assign ir_off = ir[31:16];
  assign ir_imm = ir[63:32];
  assign cls    = op[2:0];
  assign op_hi  = op[7:4];
  assign imm64  = {{32{ir_imm[31]}}, ir_imm};
  assign off64  = {{48{ir_off[15]}}, ir_off};
  assign b      = op[3] ? rs_val : imm64;
  assign off_pc = {{(PCW-16){ir_off[15]}}, ir_off};
  assign len_pc = PCW'(len);
  assign pc1    = pc + PCW'(1);
  assign pc2    = pc + PCW'(2);

  // Program store.
  logic [63:0]   prog_rdata;
  logic [AW-1:0] prog_raddr;
  logic          word_we;
  assign word_we    = cmd.load_word && (load_count < DEPTH_L);
  assign prog_raddr = cmd.prog_rd_next ? pc1[AW-1:0] : pc[AW-1:0];

  ebpf_ram #(.WIDTH(64), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk   (clk),
    .we    (word_we),
    .waddr (load_count[AW-1:0]),
    .wdata ({item.immediate, item.offset, item.src_index, item.dst_index, item.opcode}),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  // Register file; entries not written since the run started read as zero.
  logic [RF_AW-1:0] rf_raddr;
  logic [63:0]      rf_rdata, rf_rdata_m, wb_val;
  always_comb begin
    case (cmd.rsel)
      RSEL_DST: rf_raddr = RF_AW'(ir_dst);
      RSEL_SRC: rf_raddr = RF_AW'(ir_src);
      RSEL_RPT: rf_raddr = RF_AW'(rpt_k);
      default:  rf_raddr = RF_AW'(rpt_k);
    endcase
  end
  assign rf_rdata_m = rf_vld_q ? rf_rdata : 64'd0;

  ebpf_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_regs (
    .clk   (clk),
    .we    (cmd.rf_we),
    .waddr (RF_AW'(ir_dst)),
    .wdata (wb_val),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  // Scratch memory with a byte-wide port.
  logic [SAW-1:0] scr_a, scr_waddr;
  logic [7:0]     scr_rdata, scr_wdata;
  logic [63:0]    st_data;
  logic [2:0]     size_m1;
  assign st_data = (cls == CLS_ST) ? imm64 : rs_val;
  assign scr_a   = addr[SAW-1:0] + SAW'(bi);
  assign scr_waddr = cmd.clr_step ? clr_cnt : scr_a;
  assign scr_wdata = cmd.clr_step ? 8'd0 : st_data[{bi, 3'b000} +: 8];

  always_comb begin
    case (op[4:3])
      2'd0:    size_m1 = 3'd3;
      2'd1:    size_m1 = 3'd1;
      2'd2:    size_m1 = 3'd0;
      default: size_m1 = 3'd7;
    endcase
  end

  ebpf_ram #(.WIDTH(8), .DEPTH(SCRATCH_BYTES)) u_scratch (
    .clk   (clk),
    .we    (cmd.clr_step || cmd.st_write),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .raddr (scr_a),
    .rdata (scr_rdata)
  );

  // Combinational ALU operations.
  logic [4:0]  sh;
  logic [63:0] alu_res;
  assign sh = b[4:0];
  always_comb begin
    case (op_hi)
      ALU_ADD:  alu_res = rd_val + b;
      ALU_SUB:  alu_res = rd_val - b;
      ALU_OR:   alu_res = rd_val | b;
      ALU_AND:  alu_res = rd_val & b;
      ALU_LSH:  alu_res = rd_val << sh;
      ALU_RSH:  alu_res = rd_val >> sh;
      ALU_NEG:  alu_res = 64'd0 - rd_val;
      ALU_XOR:  alu_res = rd_val ^ b;
      ALU_MOV:  alu_res = b;
      ALU_ARSH: alu_res = 64'($signed(rd_val) >>> sh);
      default:  alu_res = 64'd0;
    endcase
  end

  // Low 64 bits of the product from three 32x32 partial products.
  logic [31:0] mul_x, mul_y;
  always_comb begin
    case (mul_cnt)
      2'd0:    begin mul_x = rd_val[31:0];  mul_y = b[31:0];  end
      2'd1:    begin mul_x = rd_val[31:0];  mul_y = b[63:32]; end
      default: begin mul_x = rd_val[63:32]; mul_y = b[31:0];  end
    endcase
  end

  // Signed division through the unsigned divider.
  logic [63:0] div_q, div_r, q_s, r_s;
  logic        div_busy;
  ebpf_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (rd_val[63] ? 64'd0 - rd_val : rd_val),
    .divisor   (b[63] ? 64'd0 - b : b),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );
  assign q_s = (na ^ nb) ? 64'd0 - div_q : div_q;
  assign r_s = na ? 64'd0 - div_r : div_r;

  // Write-back value; 32-bit ALU class keeps the low word only.
  logic [63:0] wb_raw;
  logic        wb_mask;
  always_comb begin
    case (cmd.wb_sel)
      WB_IMM:  wb_raw = imm64;
      WB_LDDW: wb_raw = {prog_rdata[63:32], ir_imm};
      WB_ALU:  wb_raw = alu_res;
      WB_MUL:  wb_raw = acc;
      WB_DIV:  wb_raw = (op_hi == ALU_MOD) ? r_s : q_s;
      WB_LOAD: wb_raw = ld_val;
      default: wb_raw = alu_res;
    endcase
  end
  assign wb_mask = (cls == CLS_ALU) &&
                   (cmd.wb_sel == WB_ALU || cmd.wb_sel == WB_MUL || cmd.wb_sel == WB_DIV);
  assign wb_val  = wb_mask ? {32'd0, wb_raw[31:0]} : wb_raw;

  // Branch condition.
  logic [63:0] ja, jb, sgn, sa, sb;
  logic        taken;
  assign ja  = (cls == CLS_JMP32) ? {32'd0, rd_val[31:0]} : rd_val;
  assign jb  = (cls == CLS_JMP32) ? {32'd0, b[31:0]} : b;
  assign sgn = (cls == CLS_JMP32) ? SIGN32 : SIGN64;
  assign sa  = ja ^ sgn;
  assign sb  = jb ^ sgn;
  always_comb begin
    case (op_hi)
      JMP_JA:   taken = 1'b1;
      JMP_JEQ:  taken = (ja == jb);
      JMP_JGT:  taken = (ja > jb);
      JMP_JGE:  taken = (ja >= jb);
      JMP_JNE:  taken = (ja != jb);
      JMP_JSGT: taken = (sa > sb);
      JMP_JSGE: taken = (sa >= sb);
      JMP_JLT:  taken = (ja < jb);
      JMP_JLE:  taken = (ja <= jb);
      JMP_JSLT: taken = (sa < sb);
      JMP_JSLE: taken = (sa <= sb);
      default:  taken = 1'b0;
    endcase
  end
  assign pc_tgt = pc1 + (taken ? off_pc : PCW'(0));

  // Status toward the controller.
  assign st.opcode    = op;
  assign st.bad_reg   = (ir_dst >= 4'(NUM_REGS)) || (ir_src >= 4'(NUM_REGS));
  assign st.pc_eq_len = (pc == len_pc);
  assign st.pc_over   = pc[PCW-1] || (pc > len_pc);
  assign st.step_hit  = (steps >= step_limit);
  assign st.lddw_end  = (pc1 >= len_pc);
  assign st.b_zero    = (b == 64'd0);
  assign st.b_neg     = b[63];
  assign st.b_ge32    = (b >= SHIFT_BOUND);
  assign st.addr_ok   = (addr <= SCR_BYTES - {61'd0, size_m1} - 64'd1);
  assign st.byte_last = (bi == size_m1);
  assign st.mul_last  = (mul_cnt == 2'd3);
  assign st.div_busy  = div_busy;
  assign st.clr_last  = (clr_cnt == SCR_LAST);
  assign st.rpt_last  = (rpt_k == RPT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= DEFAULT_STEP_LIMIT;
      load_count <= '0;
      len        <= '0;
      pc         <= '0;
      steps      <= '0;
      rf_valid   <= '0;
      rf_vld_q   <= 1'b0;
      rpt_k      <= '0;
      bi         <= '0;
      mul_cnt    <= '0;
      clr_cnt    <= '0;
    end else begin
      if (step_limit_we) step_limit <= step_limit_data;
      if (word_we) load_count <= load_count + LW'(1);
      if (cmd.clr_step) clr_cnt <= clr_cnt + SAW'(1);
      rf_vld_q <= (rf_raddr < RF_AW'(NUM_REGS)) && rf_valid[rf_raddr];
      if (cmd.start_run) begin
        len        <= load_count;
        load_count <= '0;
        pc         <= '0;
        steps      <= '0;
        rf_valid   <= '0;
        rpt_k      <= '0;
      end
      if (cmd.fetch) steps <= steps + 16'd1;
      if (cmd.rf_we) rf_valid[RF_AW'(ir_dst)] <= 1'b1;
      case (cmd.pc_op)
        PC_INC1: pc <= pc1;
        PC_INC2: pc <= pc2;
        PC_JUMP: pc <= pc_tgt;
        default: begin
        end
      endcase
      if (cmd.addr_load) bi <= '0;
      if (cmd.ld_cap || cmd.st_write) bi <= bi + 3'd1;
      if (cmd.mul_start) mul_cnt <= '0;
      if (cmd.mul_step) mul_cnt <= mul_cnt + 2'd1;
      if (cmd.rpt_next) rpt_k <= rpt_k + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ir_load) ir <= prog_rdata;
    if (cmd.rd_load) rd_val <= rf_rdata_m;
    if (cmd.rs_load) rs_val <= rf_rdata_m;
    if (cmd.addr_load) begin
      addr   <= ((cls == CLS_LDX) ? rs_val : rd_val) + off64;
      ld_val <= '0;
    end
    if (cmd.ld_cap) ld_val[{bi, 3'b000} +: 8] <= scr_rdata;
    if (cmd.mul_step) begin
      prod <= mul_x * mul_y;
      case (mul_cnt)
        2'd1:    acc <= prod;
        2'd2:    acc <= acc + {prod[31:0], 32'd0};
        2'd3:    acc <= acc + {prod[31:0], 32'd0};
        default: acc <= acc;
      endcase
    end
    if (cmd.div_start) begin
      na <= rd_val[63];
      nb <= b[63];
    end
    if (cmd.out_load) begin
      result.status        <= cmd.status;
      result.reg_index     <= rpt_k;
      result.reg_value     <= rf_rdata_m;
      result.end_of_report <= (rpt_k == RPT_LAST);
    end
  end

endmodule

/* sim/ebpf_program_executor_tb.sv */
// Self-checking testbench of the eBPF program executor: loads programs as items,
// predicts each eleven-item register report and compares it field by field.
// Depends on ebpf_pkg and ebpf_program_executor from the hdl folder.
module ebpf_program_executor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ebpf_pkg::*;

  localparam int PROG_WORDS   = 256;
  localparam int SCRATCH_SIZE = 4096;
  // Cycles without any accepted item before the run is declared hung.
  localparam int HANG_LIMIT   = 200000;
  localparam int RANDOM_WORDS = 420;

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  in_item_t    item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result;
  logic        step_limit_we = 1'b0;
  logic [15:0] step_limit_data = '0;

  ebpf_program_executor DUT (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .item            (item),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result),
    .step_limit_we   (step_limit_we),
    .step_limit_data (step_limit_data)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of everything the block remembers.
  // ---------------------------------------------------------------------------
  logic [63:0] pm_words [PROG_WORDS];
  logic [63:0] pm_regs [NUM_REGS];
  logic [7:0]  pm_scratch [SCRATCH_SIZE];
  int          pm_loaded;
  logic [15:0] pm_step_limit;
  logic [2:0]  pm_last_status;

  out_item_t   report_q[$];   // register reports still owed by the block
  int          error_count;
  int          send_pct;      // chance in percent that the sender idles
  int          recv_pct;      // chance in percent that the receiver stalls
  bit          allow_back;    // backward jumps only while loops stay cheap

  // Signed 64-bit divide or remainder, truncating toward zero. Working on
  // magnitudes makes the most negative value divided by -1 wrap to itself.
  function automatic logic [63:0] signed_divide(logic [63:0] a, logic [63:0] b, bit want_rem);
    logic [63:0] ua, ub, q;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    if (want_rem) begin
      q = ua % ub;
      return a[63] ? -q : q;
    end
    q = ua / ub;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  // Executes the loaded program from pc 0 and returns the run's status.
  function automatic logic [2:0] execute_program(int len);
    logic [63:0] pc, w, off, imm, a, b, r, sgn, addr;
    logic [7:0]  op;
    logic [3:0]  d, s;
    logic [2:0]  cls;
    int          nbytes, steps;
    bit          x, taken;
    pc = '0;
    steps = 0;
    forever begin
      if (pc == len) return STAT_OK;
      if (pc > len) return STAT_PC;
      if (steps >= pm_step_limit) return STAT_STEPS;
      steps++;
      w   = pm_words[pc[7:0]];
      op  = w[7:0];
      d   = w[11:8];
      s   = w[15:12];
      off = {{48{w[31]}}, w[31:16]};
      imm = {{32{w[63]}}, w[63:32]};
      if (d >= NUM_REGS || s >= NUM_REGS) return STAT_OPCODE;
      cls = op[2:0];
      x   = op[3];
      case (op[4:3])
        2'd0: nbytes = 4;
        2'd1: nbytes = 2;
        2'd2: nbytes = 1;
        default: nbytes = 8;
      endcase
      r = '0;
      taken = 1'b0;
      case (cls)
        CLS_LD: begin
          if (op == OP_LD_IMM32) begin
            pm_regs[d] = imm;
            pc++;
          end else if (op == OP_LDDW) begin
            // The wide load takes its upper half from the following word.
            if (pc + 1 >= len) return STAT_PC;
            pm_regs[d] = {pm_words[pc[7:0] + 8'd1][63:32], imm[31:0]};
            pc += 2;
          end else begin
            return STAT_OPCODE;
          end
        end
        CLS_LDX, CLS_ST, CLS_STX: begin
          if (op[7:5] != MODE_MEM) return STAT_OPCODE;
          addr = pm_regs[(cls == CLS_LDX) ? s : d] + off;
          if (addr > SCRATCH_SIZE - nbytes) return STAT_ADDR;
          if (cls == CLS_LDX) begin
            r = '0;
            for (int i = 0; i < nbytes; i++) r[8*i +: 8] = pm_scratch[addr + i];
            pm_regs[d] = r;
          end else begin
            r = (cls == CLS_ST) ? imm : pm_regs[s];
            for (int i = 0; i < nbytes; i++) pm_scratch[addr + i] = r[8*i +: 8];
          end
          pc++;
        end
        CLS_ALU, CLS_ALU64: begin
          a = pm_regs[d];
          b = x ? pm_regs[s] : imm;
          case (op[7:4])
            ALU_ADD: r = a + b;
            ALU_SUB: r = a - b;
            ALU_MUL: r = a * b;
            ALU_DIV: begin
              if (b == 0) return STAT_DIV0;
              r = signed_divide(a, b, 1'b0);
            end
            ALU_OR:  r = a | b;
            ALU_AND: r = a & b;
            ALU_LSH: begin
              if (b >= SHIFT_BOUND) return STAT_SHIFT;
              r = a << b[4:0];
            end
            ALU_RSH: begin
              if (b >= SHIFT_BOUND) return STAT_SHIFT;
              r = a >> b[4:0];
            end
            ALU_NEG: begin
              if (x) return STAT_OPCODE;
              r = -a;
            end
            ALU_MOD: begin
              if (b == 0 || b[63]) return STAT_MOD;
              r = signed_divide(a, b, 1'b1);
            end
            ALU_XOR: r = a ^ b;
            ALU_MOV: r = b;
            ALU_ARSH: begin
              if (b >= SHIFT_BOUND) return STAT_SHIFT;
              r = $signed(a) >>> b[4:0];
            end
            default: return STAT_OPCODE;
          endcase
          // 32-bit operations keep only the low word, zero-extended.
          if (cls == CLS_ALU) r = {32'd0, r[31:0]};
          pm_regs[d] = r;
          pc++;
        end
        CLS_JMP, CLS_JMP32: begin
          a = pm_regs[d];
          b = x ? pm_regs[s] : imm;
          sgn = SIGN64;
          if (cls == CLS_JMP32) begin
            a = {32'd0, a[31:0]};
            b = {32'd0, b[31:0]};
            sgn = SIGN32;
          end
          case (op[7:4])
            JMP_JA: begin
              if (x) return STAT_OPCODE;
              taken = 1'b1;
            end
            JMP_JEQ:  taken = (a == b);
            JMP_JGT:  taken = (a > b);
            JMP_JGE:  taken = (a >= b);
            JMP_JSET: taken = 1'b0;
            JMP_JNE:  taken = (a != b);
            JMP_JSGT: taken = ((a ^ sgn) > (b ^ sgn));
            JMP_JSGE: taken = ((a ^ sgn) >= (b ^ sgn));
            JMP_JLT:  taken = (a < b);
            JMP_JLE:  taken = (a <= b);
            JMP_JSLT: taken = ((a ^ sgn) < (b ^ sgn));
            JMP_JSLE: taken = ((a ^ sgn) <= (b ^ sgn));
            default:  return STAT_OPCODE;
          endcase
          // A negative target wraps to a huge pc and counts as overflow.
          pc = pc + 1 + (taken ? off : 64'd0);
        end
        default: return STAT_OPCODE;
      endcase
    end
  endfunction

  // Takes one accepted item into the program store; a last word starts the
  // run and queues the eleven report items that follow it.
  function automatic void absorb_word(in_item_t it);
    logic [63:0] w;
    int          len;
    w = {it.immediate, it.offset, it.src_index, it.dst_index, it.opcode};
    if (pm_loaded < PROG_WORDS) begin
      pm_words[pm_loaded] = w;
      pm_loaded++;
    end
    if (!it.last) return;
    len = pm_loaded;
    pm_loaded = 0;
    for (int k = 0; k < NUM_REGS; k++) pm_regs[k] = '0;
    pm_last_status = execute_program(len);
    for (int k = 0; k < NUM_REGS; k++)
      report_q.push_back('{pm_last_status, 4'(k), pm_regs[k], k == NUM_REGS - 1});
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: checks every accepted item, randomizes the stall and watches
  // for a hang. Outputs are sampled at the edge, before the block updates them.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (report_q.size() == 0) begin
          report_mismatch("unexpected result item", 64'(result), 64'd0);
        end else begin
          want = report_q.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", 64'(result.status), 64'(want.status));
          if (result.reg_index !== want.reg_index)
            report_mismatch("reg_index", 64'(result.reg_index), 64'(want.reg_index));
          if (result.reg_value !== want.reg_value)
            report_mismatch("reg_value", result.reg_value, want.reg_value);
          if (result.end_of_report !== want.end_of_report)
            report_mismatch("end_of_report", 64'(result.end_of_report),
                            64'(want.end_of_report));
        end
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", HANG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    result_stall <= (recv_pct > 0) && ($urandom_range(99) < recv_pct);
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  int words_sent;

  // Offers one item and waits until the block takes it. Valid stays high after
  // acceptance so that back-to-back items need no dip; callers that pause
  // lower it first.
  task automatic push_word(in_item_t it);
    while (send_pct > 0 && $urandom_range(99) < send_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    absorb_word(it);
    words_sent++;
  endtask

  // Holds the sender until every owed report item has arrived.
  task automatic drain_reports();
    item_valid <= 1'b0;
    @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
  endtask

  // Writes the step limit while the block is idle. The extra cycles cover the
  // block returning to idle after the final report item.
  task automatic write_step_limit(logic [15:0] value);
    drain_reports();
    repeat (20) @(posedge clk);
    step_limit_we <= 1'b1;
    step_limit_data <= value;
    @(posedge clk);
    step_limit_we <= 1'b0;
    pm_step_limit = value;
  endtask

  function automatic in_item_t make_word(logic [7:0] op, logic [3:0] d, logic [3:0] s,
                                         logic [15:0] off, logic [31:0] imm, logic last);
    return '{op, d, s, off, imm, last};
  endfunction

  // Mostly legal register numbers, now and then one above r10 (11 to 15).
  function automatic logic [3:0] pick_reg();
    return ($urandom_range(99) < 2) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
  endfunction

  in_item_t prog_q[$];

  // Builds one random program of well-formed instructions with random content
  // and a sprinkling of broken words, then sends it with the last flag set.
  task automatic send_random_program();
    logic [3:0]  alu_ops [13];
    logic [3:0]  jmp_ops [12];
    logic [3:0]  opn, rb;
    logic [2:0]  cls;
    logic [1:0]  size;
    logic [31:0] imm;
    logic [15:0] off;
    int          count, sel;
    bit          x;
    alu_ops = '{ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_OR, ALU_AND, ALU_LSH,
                ALU_RSH, ALU_NEG, ALU_MOD, ALU_XOR, ALU_MOV, ALU_ARSH};
    jmp_ops = '{JMP_JA, JMP_JEQ, JMP_JGT, JMP_JGE, JMP_JSET, JMP_JNE, JMP_JSGT,
                JMP_JSGE, JMP_JLT, JMP_JLE, JMP_JSLT, JMP_JSLE};
    prog_q.delete();
    count = $urandom_range(1, 10);
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        cls = $urandom_range(1) ? CLS_ALU64 : CLS_ALU;
        opn = alu_ops[$urandom_range(12)];
        x = 1'($urandom_range(1));
        if (opn == ALU_NEG && $urandom_range(9) != 0) x = 1'b0;
        if (opn inside {ALU_LSH, ALU_RSH, ALU_ARSH} && $urandom_range(3) != 0)
          imm = $urandom_range(0, 34);
        else if (opn inside {ALU_DIV, ALU_MOD} && $urandom_range(5) == 0)
          imm = $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF;
        else
          imm = $urandom;
        prog_q.push_back(make_word({opn, x, cls}, pick_reg(), pick_reg(), 16'($urandom),
                                   imm, 1'b0));
      end else if (sel < 45) begin
        // Seed a register with a wide value.
        prog_q.push_back(make_word($urandom_range(1) ? {ALU_MOV, 1'b0, CLS_ALU64} : OP_LD_IMM32,
                                   4'($urandom_range(0, 10)), 4'($urandom), 16'($urandom),
                                   $urandom, 1'b0));
      end else if (sel < 52) begin
        prog_q.push_back(make_word(OP_LDDW, pick_reg(), 4'($urandom), 16'($urandom),
                                   $urandom, 1'b0));
        prog_q.push_back(make_word(8'h00, 4'd0, 4'd0, 16'd0, $urandom, 1'b0));
      end else if (sel < 72) begin
        // Point a base register into scratch memory, then access it.
        rb = 4'($urandom_range(0, 10));
        prog_q.push_back(make_word({ALU_MOV, 1'b0, CLS_ALU64}, rb, 4'd0, 16'd0,
                                   $urandom_range(0, SCRATCH_SIZE + 4), 1'b0));
        cls = 3'($urandom_range(CLS_LDX, CLS_STX));
        size = 2'($urandom);
        off = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16) - 8);
        if (cls == CLS_LDX)
          prog_q.push_back(make_word({MODE_MEM, size, cls}, pick_reg(), rb, off, $urandom, 1'b0));
        else
          prog_q.push_back(make_word({MODE_MEM, size, cls}, rb, pick_reg(), off, $urandom, 1'b0));
      end else if (sel < 92) begin
        cls = $urandom_range(1) ? CLS_JMP : CLS_JMP32;
        opn = jmp_ops[$urandom_range(11)];
        x = (opn == JMP_JA) ? ($urandom_range(9) == 0) : 1'($urandom_range(1));
        off = (allow_back && $urandom_range(4) == 0) ? 16'($urandom_range(0, 3) - 3)
                                                     : 16'($urandom_range(0, 3));
        imm = $urandom_range(1) ? 32'($urandom_range(0, 3)) : $urandom;
        prog_q.push_back(make_word({opn, x, cls}, pick_reg(), pick_reg(), off, imm, 1'b0));
      end else begin
        // Arbitrary word; with a large step limit keep jumps short and forward.
        off = allow_back ? 16'($urandom) : 16'($urandom_range(0, 15));
        prog_q.push_back(make_word(8'($urandom), 4'($urandom), 4'($urandom), off,
                                   $urandom, 1'b0));
      end
    end
    prog_q[prog_q.size() - 1].last = 1'b1;
    foreach (prog_q[i]) push_word(prog_q[i]);
  endtask

  // Directed rows; the expected status and r0 are typed in where obvious.
  typedef struct {
    in_item_t    word;
    logic [2:0]  want_status;
    bit          check_r0;
    logic [63:0] want_r0;
  } directed_row_t;

  directed_row_t directed_tab[$];

  function automatic void add_row(logic [7:0] op, logic [3:0] d, logic [3:0] s,
                                  logic [15:0] off, logic [31:0] imm, logic last,
                                  logic [2:0] st, bit chk, logic [63:0] r0);
    directed_tab.push_back('{make_word(op, d, s, off, imm, last), st, chk, r0});
  endfunction

  initial begin
    logic [7:0] mov64, ja64;
    error_count = 0;
    words_sent = 0;
    pm_loaded = 0;
    pm_step_limit = DEFAULT_STEP_LIMIT;
    pm_last_status = STAT_OK;
    foreach (pm_regs[i]) pm_regs[i] = '0;
    foreach (pm_scratch[i]) pm_scratch[i] = '0;
    send_pct = 31;
    recv_pct = 61;
    allow_back = 1'b1;
    mov64 = {ALU_MOV, 1'b0, CLS_ALU64};
    ja64  = {JMP_JA, 1'b0, CLS_JMP};

    // Move of all ones into r0.
    add_row(mov64, 4'd0, 4'd0, 16'd0, 32'hFFFF_FFFF, 1'b1, STAT_OK, 1, '1);
    // Wide immediate load spanning two words.
    add_row(OP_LDDW, 4'd1, 4'd0, 16'd0, 32'h89AB_CDEF, 1'b0, STAT_OK, 0, '0);
    add_row(OP_LD_IMM32, 4'd0, 4'd0, 16'd0, 32'h7FFF_FFFF, 1'b1, STAT_OK, 1, '0);
    // Error cases, each a one-word program.
    add_row({ALU_DIV, 1'b0, CLS_ALU64}, 4'd0, 4'd0, 16'd0, 32'd0, 1'b1, STAT_DIV0, 1, '0);
    add_row({ALU_LSH, 1'b0, CLS_ALU64}, 4'd0, 4'd0, 16'd0, 32'd32, 1'b1, STAT_SHIFT, 1, '0);
    add_row({ALU_MOD, 1'b0, CLS_ALU64}, 4'd0, 4'd0, 16'd0, 32'hFFFF_FFFF, 1'b1,
            STAT_MOD, 1, '0);
    add_row(8'h95, 4'd0, 4'd0, 16'd0, 32'd0, 1'b1, STAT_OPCODE, 1, '0);
    add_row(mov64, 4'd15, 4'd15, 16'd0, 32'd5, 1'b1, STAT_OPCODE, 1, '0);
    add_row({MODE_MEM, 2'd3, CLS_ST}, 4'd10, 4'd0, 16'hFFFF, 32'd1, 1'b1, STAT_ADDR, 1, '0);
    // Store and reload the top doubleword of scratch, then jump far past the end.
    add_row({MODE_MEM, 2'd3, CLS_ST}, 4'd0, 4'd0, 16'd4088, 32'h8000_0000, 1'b0,
            STAT_OK, 0, '0);
    add_row({MODE_MEM, 2'd3, CLS_LDX}, 4'd2, 4'd0, 16'd4088, 32'd0, 1'b0, STAT_OK, 0, '0);
    add_row(ja64, 4'd0, 4'd0, 16'h7FFF, 32'd0, 1'b1, STAT_PC, 1, '0);
    // Wide load as the only word: its second half lies past the end.
    add_row(OP_LDDW, 4'd0, 4'd0, 16'd0, 32'd7, 1'b1, STAT_PC, 1, '0);
    // Jump to itself until the step limit stops it.
    add_row(ja64, 4'd0, 4'd0, 16'hFFFF, 32'd0, 1'b1, STAT_STEPS, 1, '0);
    // 32-bit jump-always with zero distance.
    add_row({JMP_JA, 1'b0, CLS_JMP32}, 4'd0, 4'd0, 16'd0, 32'd0, 1'b1, STAT_OK, 1, '0);
    // Arithmetic shift, negate and 32-bit multiply starting from the most negative
    // 32-bit value, closed by a jump-if-set that must not be taken.
    add_row(mov64, 4'd3, 4'd0, 16'd0, 32'h8000_0000, 1'b0, STAT_OK, 0, '0);
    add_row({ALU_ARSH, 1'b0, CLS_ALU64}, 4'd3, 4'd0, 16'd0, 32'd31, 1'b0, STAT_OK, 0, '0);
    add_row({ALU_NEG, 1'b0, CLS_ALU64}, 4'd3, 4'd0, 16'd0, 32'd0, 1'b0, STAT_OK, 0, '0);
    add_row({ALU_MUL, 1'b0, CLS_ALU}, 4'd3, 4'd0, 16'd0, 32'd3, 1'b0, STAT_OK, 0, '0);
    add_row({JMP_JSET, 1'b0, CLS_JMP}, 4'd3, 4'd0, 16'd5, 32'hFFFF_FFFF, 1'b1,
            STAT_OK, 1, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_tab[i]) begin
      push_word(directed_tab[i].word);
      if (directed_tab[i].word.last) begin
        if (pm_last_status !== directed_tab[i].want_status)
          report_mismatch("predicted status", 64'(pm_last_status),
                          64'(directed_tab[i].want_status));
        if (directed_tab[i].check_r0 && pm_regs[0] !== directed_tab[i].want_r0)
          report_mismatch("predicted r0", pm_regs[0], directed_tab[i].want_r0);
      end
    end

    // Random phases at step limits of 1, 65535 and 20.
    write_step_limit(16'd1);
    while (words_sent < 80) send_random_program();

    write_step_limit(16'hFFFF);
    allow_back = 1'b0;
    send_pct = 61;
    recv_pct = 31;
    while (words_sent < 130) send_random_program();

    write_step_limit(16'd20);
    allow_back = 1'b1;
    send_pct = 0;
    recv_pct = 0;
    while (words_sent < 150) send_random_program();
    drain_reports();
    // A full store: 256 words, then a last word that is dropped but still
    // starts the run.
    for (int i = 0; i <= PROG_WORDS; i++)
      push_word(make_word({ALU_MOV, 1'b0, CLS_ALU64}, 4'($urandom_range(0, 10)), 4'd0,
                          16'd0, $urandom, i == PROG_WORDS));
    while (words_sent < RANDOM_WORDS) send_random_program();

    drain_reports();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
